// ===== sv/md5_message_digest_assert.svh =====
// assertion macros for the md5 message digest block
// used by md5_message_digest; no other dependencies
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH
`ifndef ASSERT_OFF
`define MD5_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define MD5_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define MD5_ASSERT_IMPLIES(label, clk, rst, pre, post)
`define MD5_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== sv/md5_pkg.sv =====
// package for the md5 message digest block: constants, tables, helpers
// no dependencies
package md5_pkg;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   // write request into the block word memory
   typedef struct packed {
      logic       en;
      logic [3:0] addr;
      logic [3:0] be;
      logic [31:0] data;
   } mem_wr_type;

   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
         6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
         6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
         4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
         4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
   endfunction

   // message word index used by a round
   function automatic logic [3:0] word_index(input logic [5:0] i);
      logic [7:0] g;
      case (i[5:4])
         2'd0: g = {2'b00, i};
         2'd1: g = 8'(5 * i + 1);
         2'd2: g = 8'(3 * i + 5);
         default: g = 8'(7 * i);
      endcase
      return g[3:0];
   endfunction

   function automatic logic [31:0] bswap(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

// ===== sv/md5_message_digest.sv =====
// md5 message digest top level: byte packer, padding sequencer, output register
// depends on md5_pkg, md5_word_ram, md5_round_core and the assertion header
// a byte is written to the block memory as it is accepted; a block-filling byte starts a compression
// an end-of-message byte adds padding writes, the length words and one or two compressions
// new bytes are held off while the single round unit is busy and during padding
// reset is synchronous: chaining words and bit count return to initial values
`include "md5_message_digest_assert.svh"
module md5_message_digest (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // data_byte
   input  logic         req_tuser,  // byte_present
   input  logic         req_tlast,  // end_of_message
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata   // digest_first, digest_second
);

   typedef enum logic [2:0] {
      ACCEPT, WAIT_BYTE, PAD, PAD_COMP, LEN, LEN_COMP, OUTPUT
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] count_ff, count_in;
   logic [5:0]  pos_ff, pos_in;
   logic        out_v_ff, out_v_in;
   logic [127:0] out_d_ff;
   md5_pkg::mem_wr_type wr;
   logic        start, init, busy;
   logic [3:0]  rd_addr;
   logic [31:0] rd_data;
   logic [127:0] chain;
   logic        acc;

   md5_word_ram u_ram (.clock, .wr, .rd_addr, .rd_data);
   md5_round_core u_core (.clock, .reset, .start, .init, .busy, .rd_addr, .rd_data, .chain);

   assign acc = req_tvalid && req_tready;
   assign req_tready = (state_ff == ACCEPT) && !busy;

   // sequencer: byte writes, padding sweep, length words, digest output
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      start = 1'b0;
      init = 1'b0;
      wr = '0;
      out_v_in = out_v_ff && !rsp_tready;
      case (state_ff)
         ACCEPT: begin
            if (acc) begin
               pos_in = count_ff[8:3];
               if (req_tuser) begin
                  wr.en = 1'b1;
                  wr.addr = count_ff[8:5];
                  wr.be = 4'b0001 << count_ff[4:3];
                  wr.data = {4{req_tdata}};
                  count_in = count_ff + 64'd8;
                  pos_in = 6'(count_ff[8:3] + 6'd1);
                  start = (count_ff[8:3] == 6'h3f);
               end
               if (req_tlast) begin
                  state_in = WAIT_BYTE;
               end
            end
         end
         WAIT_BYTE: begin
            if (!busy) begin
               // first padding byte, then zero the rest of the word
               wr.en = 1'b1;
               wr.addr = pos_ff[5:2];
               wr.data = {4{8'h80}} & ({32'hff} << {pos_ff[1:0], 3'b000});
               wr.be = 4'b1111 << pos_ff[1:0];
               pos_in = {4'(pos_ff[5:2] + 4'd1), 2'b00};
               if (pos_ff[5:2] == 4'd15) begin
                  state_in = PAD_COMP;
                  start = 1'b1;
               end else begin
                  state_in = PAD;
               end
            end
         end
         PAD: begin
            wr.en = 1'b1;
            wr.addr = pos_ff[5:2];
            wr.be = 4'b1111;
            wr.data = '0;
            pos_in = {4'(pos_ff[5:2] + 4'd1), 2'b00};
            if (pos_ff[5:2] == 4'd15) begin
               // no room left for the length: compress and start a second block
               state_in = PAD_COMP;
               start = 1'b1;
            end else if (pos_ff[5:2] >= 4'd13) begin
               state_in = LEN;
               pos_in = {4'd14, 2'b00};
            end
         end
         PAD_COMP: begin
            // second block of zeros after an early compression
            if (!busy) begin
               if (pos_ff[5:2] >= 4'd14) begin
                  state_in = LEN;
               end else begin
                  wr.en = 1'b1;
                  wr.addr = pos_ff[5:2];
                  wr.be = 4'b1111;
                  wr.data = '0;
                  pos_in = {4'(pos_ff[5:2] + 4'd1), 2'b00};
               end
            end
         end
         LEN: begin
            wr.en = 1'b1;
            wr.be = 4'b1111;
            wr.addr = pos_ff[5:2];
            wr.data = pos_ff[2] ? count_ff[63:32] : count_ff[31:0];
            pos_in = {4'(pos_ff[5:2] + 4'd1), 2'b00};
            if (pos_ff[5:2] == 4'd15) begin
               start = 1'b1;
               state_in = LEN_COMP;
            end
         end
         LEN_COMP: begin
            if (!busy && !out_v_ff) begin
               out_v_in = 1'b1;
               state_in = ACCEPT;
               init = 1'b1;
               count_in = '0;
            end
         end
         default: state_in = ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ACCEPT;
         count_ff <= '0;
         pos_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pos_ff <= pos_in;
         out_v_ff <= out_v_in;
      end
      if (state_ff == LEN_COMP && !busy && !out_v_ff) begin
         out_d_ff <= {md5_pkg::bswap(chain[127:96]), md5_pkg::bswap(chain[95:64]),
                      md5_pkg::bswap(chain[63:32]), md5_pkg::bswap(chain[31:0])};
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {out_d_ff[63:0], out_d_ff[127:64]};

   `MD5_ASSERT_IMPLIES(a_ready_idle, clock, reset, req_tready, !busy)
   `MD5_ASSERT_NEXT(a_digest_clears, clock, reset, init, count_ff == 64'd0)
   `MD5_ASSERT_IMPLIES(a_no_write_busy, clock, reset, wr.en && state_ff != ACCEPT, !busy)

endmodule

// ===== sv/md5_word_ram.sv =====
// block word memory: sixteen 32-bit words, byte write enables, registered read
// depends on md5_pkg
module md5_word_ram (
   input  logic               clock,
   input  md5_pkg::mem_wr_type wr,
   input  logic [3:0]         rd_addr,
   output logic [31:0]        rd_data
);

   logic [31:0] mem [16];

   // byte-masked write, registered read
   always_ff @(posedge clock) begin
      for (int b = 0; b < 4; b++) begin
         if (wr.en && wr.be[b]) begin
            mem[wr.addr][8*b +: 8] <= wr.data[8*b +: 8];
         end
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/md5_round_core.sv =====
// md5 compression: one round a cycle over words read from the block memory
// depends on md5_pkg
module md5_round_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        init,
   output logic        busy,
   output logic [3:0]  rd_addr,
   input  logic [31:0] rd_data,
   output logic [127:0] chain
);

   typedef enum logic [1:0] {IDLE, PRIME, RUN, FOLD} state_type;

   state_type   state_ff, state_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [31:0] h_ff [4];
   logic [31:0] h_in [4];
   logic [31:0] f, sum, rot;
   logic [4:0]  s;

   // round function and rotation
   always_comb begin
      case (rnd_ff[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      s = md5_pkg::rot_amount(rnd_ff);
      sum = a_ff + f + md5_pkg::round_const(rnd_ff) + rd_data;
      rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
   end

   // address of next word: prefetch one round ahead
   assign rd_addr = (state_ff == RUN) ? md5_pkg::word_index(6'(rnd_ff + 6'd1))
                                      : md5_pkg::word_index(6'd0);

   always_comb begin
      state_in = state_ff;
      rnd_in = rnd_ff;
      {a_in, b_in, c_in, d_in} = {a_ff, b_ff, c_ff, d_ff};
      h_in = h_ff;
      case (state_ff)
         IDLE: begin
            if (start) begin
               state_in = PRIME;
            end
         end
         PRIME: begin
            {a_in, b_in, c_in, d_in} = {h_ff[0], h_ff[1], h_ff[2], h_ff[3]};
            rnd_in = '0;
            state_in = RUN;
         end
         RUN: begin
            a_in = d_ff;
            d_in = c_ff;
            c_in = b_ff;
            b_in = b_ff + rot;
            rnd_in = 6'(rnd_ff + 6'd1);
            if (rnd_ff == 6'd63) begin
               state_in = FOLD;
            end
         end
         FOLD: begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
      if (init) begin
         h_in[0] = md5_pkg::IV_A;
         h_in[1] = md5_pkg::IV_B;
         h_in[2] = md5_pkg::IV_C;
         h_in[3] = md5_pkg::IV_D;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rnd_ff <= '0;
         h_ff[0] <= md5_pkg::IV_A;
         h_ff[1] <= md5_pkg::IV_B;
         h_ff[2] <= md5_pkg::IV_C;
         h_ff[3] <= md5_pkg::IV_D;
      end else begin
         state_ff <= state_in;
         rnd_ff <= rnd_in;
         h_ff <= h_in;
      end
      {a_ff, b_ff, c_ff, d_ff} <= {a_in, b_in, c_in, d_in};
   end

   assign busy = (state_ff != IDLE);
   assign chain = {h_ff[0], h_ff[1], h_ff[2], h_ff[3]};

endmodule
